// File: src/set_assoc_lru_cache_model_macros.svh
// assertion macros for the cache model
`ifndef SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH
// assert that a implies b in the next cycle
`define SALC_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
// assert that a implies b in the same cycle
`define SALC_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`endif

// File: src/salc_pkg.sv
// shared types and constants for the cache model
`default_nettype none
package salc_pkg;
  localparam int MAX_SETS = 1024;
  localparam int MAX_WAYS = 16;
  localparam int SET_W = $clog2(MAX_SETS);
  localparam int WAY_W = $clog2(MAX_WAYS);
  localparam int ENT_W = SET_W + WAY_W;
  localparam int ENTRIES = MAX_SETS * MAX_WAYS;
  localparam logic [2:0] REG_EPL = 3'd0;
  localparam logic [2:0] REG_YLC = 3'd1;
  localparam logic [2:0] REG_SETS = 3'd2;
  localparam logic [2:0] REG_WAYS = 3'd3;

  typedef struct packed {
    logic        vector_select;
    logic [30:0] element_index;
  } in_req_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  way_used;
    logic [47:0] access_count;
    logic [47:0] miss_count;
  } out_res_t;

  typedef struct packed {
    logic [SET_W-1:0] set;
    logic [31:0]      tag;
  } line_req_t;

  typedef struct packed {
    logic [6:0]  epl;
    logic [30:0] ylc;
    logic [10:0] sets;
    logic [6:0]  ways;
  } cfg_t;
endpackage
`default_nettype wire

// File: src/set_assoc_lru_cache_model.sv
// top level of the set-associative true lru cache model
// the front splits each request by two bit-serial divisions and takes no new request
// until it has handed the last one to the queue; the back searches the ways one by one,
// overlapped with the front through a two-entry queue
// reset: synchronous active low, counters, stamp clock and config reset at once
// valid bits clear over all 1024 sets after reset while the back holds off requests
`default_nettype none
`include "set_assoc_lru_cache_model_macros.svh"
module set_assoc_lru_cache_model (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire salc_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output salc_pkg::out_res_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import salc_pkg::*;

  logic [6:0]  epl_r;
  logic [30:0] ylc_r;
  logic [10:0] sets_r;
  logic [4:0]  ways_r;
  cfg_t        cfg;
  logic        f_valid, f_ready, b_valid, b_ready, busy;
  line_req_t   f_data, b_data;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign cfg.epl = (epl_r == 7'd0) ? 7'd1 : epl_r;
  assign cfg.ylc = ylc_r;
  assign cfg.sets = (sets_r == 11'd0) ? 11'd1 :
                    (sets_r > 11'(MAX_SETS)) ? 11'(MAX_SETS) : sets_r;
  assign cfg.ways = {2'd0, ways_r};

  always_comb begin
    case (paddr[3:2])
      REG_EPL[1:0]:  prdata = {25'd0, epl_r};
      REG_YLC[1:0]:  prdata = {1'b0, ylc_r};
      REG_SETS[1:0]: prdata = {21'd0, sets_r};
      REG_WAYS[1:0]: prdata = {27'd0, ways_r};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epl_r <= 7'd8;
      ylc_r <= 31'd0;
      sets_r <= 11'd64;
      ways_r <= 5'd8;
    end else if (wr && paddr[1:0] == 2'd0) begin
      case (paddr[3:2])
        REG_EPL[1:0]:  epl_r <= pwdata[6:0];
        REG_YLC[1:0]:  ylc_r <= pwdata[30:0];
        REG_SETS[1:0]: sets_r <= pwdata[10:0];
        REG_WAYS[1:0]: ways_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  salc_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  salc_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  salc_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .busy(busy)
  );

  `SALC_ASSERT_NOW(a_out_busy, out_valid, busy)
  `SALC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `SALC_ASSERT_NOW(a_way_range, out_valid, {1'b0, out_data.way_used} < cfg.ways[4:0] ||
                   cfg.ways == 7'd0 || cfg.ways > 7'd16)
endmodule
`default_nettype wire

// File: src/salc_front.sv
// front end: line address and set/tag split by iterative division
`default_nettype none
module salc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire salc_pkg::cfg_t     cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire salc_pkg::in_req_t  in_data,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output salc_pkg::line_req_t     q_data
);
  import salc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV1 = 2'd1;
  localparam logic [1:0] S_DIV2 = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [10:0] dvs_r, dvs_nxt;
  logic        sel_r, sel_nxt;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] addr;

  assign in_ready = (state_r == S_IDLE);
  assign q_valid  = (state_r == S_OUT);
  assign q_data.set = rem_r[SET_W-1:0];
  assign q_data.tag = quo_r;
  assign rem_sh = {rem_r[30:0], quo_r[31]};
  assign trial = {1'b0, rem_sh} - {22'd0, dvs_r};
  assign addr = quo_r + (sel_r ? {1'b0, cfg.ylc} : 32'd0);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    sel_nxt = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          quo_nxt = {1'b0, in_data.element_index};
          rem_nxt = 32'd0;
          sel_nxt = in_data.vector_select;
          dvs_nxt = {4'd0, cfg.epl};
          cnt_nxt = 6'd32;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1, S_DIV2: begin
        if (cnt_r == 6'd0) begin
          if (state_r == S_DIV1) begin
            quo_nxt = addr;
            rem_nxt = 32'd0;
            dvs_nxt = cfg.sets;
            cnt_nxt = 6'd32;
            state_nxt = S_DIV2;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          cnt_nxt = cnt_r - 6'd1;
          if (!trial[32]) begin
            rem_nxt = trial[31:0];
            quo_nxt = {quo_r[30:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;
            quo_nxt = {quo_r[30:0], 1'b0};
          end
        end
      end
      S_OUT: begin
        if (q_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    sel_r <= sel_nxt;
  end
endmodule
`default_nettype wire

// File: src/salc_queue.sv
// two-entry request queue between front and back
`default_nettype none
module salc_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_valid,
  output logic                     wr_ready,
  input  wire salc_pkg::line_req_t wr_data,
  output logic                     rd_valid,
  input  wire logic                rd_ready,
  output salc_pkg::line_req_t      rd_data
);
  import salc_pkg::*;

  line_req_t   mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

// File: src/salc_back.sv
// back end: way search, lru victim choice, fill and counters
`default_nettype none
module salc_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire salc_pkg::cfg_t      cfg,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire salc_pkg::line_req_t q_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output salc_pkg::out_res_t       out_data,
  output logic                     busy
);
  import salc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  logic [31:0] tag_mem [ENTRIES];
  logic [39:0] stamp_mem [ENTRIES];
  logic [MAX_WAYS-1:0] valid_mem [MAX_SETS];

  logic [2:0]       state_r, state_nxt;
  line_req_t        req_r;
  logic [WAY_W:0]   w_r;
  logic [WAY_W:0]   ways;
  logic [31:0]      tag_q;
  logic [39:0]      stamp_q;
  logic             hit_r, inv_r;
  logic [WAY_W-1:0] ch_r;
  logic [39:0]      best_r;
  logic [39:0]      clk_r;
  logic [47:0]      acc_r, mis_r;
  logic [MAX_WAYS-1:0] vrow_q;
  logic             vw;
  logic [WAY_W-1:0] wi;
  logic [ENT_W-1:0] rd_addr, wr_addr;
  logic [SET_W-1:0] clr_r;
  logic [MAX_WAYS-1:0] ch_bit;
  logic             v_we;
  logic [SET_W-1:0] v_addr;
  logic [MAX_WAYS-1:0] v_wdata;

  assign ways = (cfg.ways == 7'd0) ? 5'd1 :
                (cfg.ways > 7'(MAX_WAYS)) ? 5'(MAX_WAYS) : cfg.ways[WAY_W:0];
  assign wi = w_r[WAY_W-1:0];
  assign vw = vrow_q[wi];
  assign rd_addr = {req_r.set, wi};
  assign wr_addr = {req_r.set, ch_r};
  assign ch_bit = {{(MAX_WAYS-1){1'b0}}, 1'b1} << ch_r;
  assign v_we = (state_r == S_CLR) || (state_r == S_WR && !hit_r);
  assign v_addr = (state_r == S_CLR) ? clr_r : req_r.set;
  assign v_wdata = (state_r == S_CLR) ? '0 : (vrow_q | ch_bit);
  assign q_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign busy = (state_r != S_IDLE);
  assign out_data.hit = hit_r;
  assign out_data.way_used = 4'(ch_r);
  assign out_data.access_count = acc_r;
  assign out_data.miss_count = mis_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_RD;
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if ((vw && tag_q == req_r.tag) || (w_r + 1'b1 == ways)) state_nxt = S_WR;
        else state_nxt = S_RD;
      end
      S_WR: state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      S_CLR: if (clr_r == SET_W'(MAX_SETS - 1)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    tag_q <= tag_mem[rd_addr];
    stamp_q <= stamp_mem[rd_addr];
    vrow_q <= valid_mem[req_r.set];
    if (v_we) valid_mem[v_addr] <= v_wdata;
    if (state_r == S_WR) begin
      stamp_mem[wr_addr] <= clk_r;
      if (!hit_r) tag_mem[wr_addr] <= req_r.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      clk_r <= 40'd0;
      acc_r <= 48'd0;
      mis_r <= 48'd0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            req_r <= q_data;
            w_r <= '0;
            hit_r <= 1'b0;
            inv_r <= 1'b0;
            ch_r <= '0;
            if (acc_r != '1) acc_r <= acc_r + 48'd1;
            if (clk_r != '1) clk_r <= clk_r + 40'd1;
          end
        end
        S_CMP: begin
          w_r <= w_r + 1'b1;
          if (vw && tag_q == req_r.tag) begin
            hit_r <= 1'b1;
            ch_r <= wi;
          end else if (!inv_r) begin
            if (!vw) begin
              inv_r <= 1'b1;
              ch_r <= wi;
            end else if (w_r == '0 || stamp_q < best_r) begin
              best_r <= stamp_q;
              ch_r <= wi;
            end
          end
        end
        S_WR: begin
          if (!hit_r) begin
            if (mis_r != '1) mis_r <= mis_r + 48'd1;
          end
        end
        S_CLR: clr_r <= clr_r + 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: test/testbench.sv
// self-checking testbench for the set-associative true lru cache model
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import salc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    bit        vs;
    bit [30:0] idx;
    bit        typed;
    bit        hit;
    bit [3:0]  way;
    bit [47:0] acc;
    bit [47:0] mis;
  } vector_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_res_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  set_assoc_lru_cache_model i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // cache image kept by the testbench
  logic [31:0] way_tag [ENTRIES];
  bit          way_valid [ENTRIES];
  logic [39:0] way_stamp [ENTRIES];
  logic [39:0] lru_clock;
  logic [47:0] n_access;
  logic [47:0] n_miss;
  logic [6:0]  c_epl;
  logic [30:0] c_ylc;
  logic [10:0] c_sets;
  logic [4:0]  c_ways;

  out_res_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  bit sender_idle_on = 1'b1;
  bit receiver_idle_on = 1'b1;
  int stall_left = 0;

  function automatic out_res_t cache_lookup(bit vs, bit [30:0] idx);
    longint unsigned epl, sets, ways, line, set, tag, base, w, pick, best;
    bit hit, found;
    out_res_t r;
    epl = (c_epl == 0) ? 1 : c_epl;
    sets = (c_sets == 0) ? 1 : ((c_sets > MAX_SETS) ? MAX_SETS : c_sets);
    ways = (c_ways == 0) ? 1 : ((c_ways > MAX_WAYS) ? MAX_WAYS : c_ways);
    line = longint'(idx) / epl;
    if (vs) line += c_ylc;
    set = line % sets;
    tag = line / sets;
    base = set * MAX_WAYS;
    hit = 0;
    found = 0;
    pick = 0;
    if (n_access != '1) n_access++;
    if (lru_clock != '1) lru_clock++;
    for (w = 0; w < ways; w++) begin
      if (!hit && way_valid[base + w] && way_tag[base + w] == tag[31:0]) begin
        hit = 1;
        pick = w;
      end
    end
    if (hit) begin
      way_stamp[base + pick] = lru_clock;
    end else begin
      for (w = 0; w < ways; w++) begin
        if (!found && !way_valid[base + w]) begin
          found = 1;
          pick = w;
        end
      end
      if (!found) begin
        best = way_stamp[base];
        pick = 0;
        for (w = 1; w < ways; w++) begin
          if (way_stamp[base + w] < best) begin
            best = way_stamp[base + w];
            pick = w;
          end
        end
      end
      way_tag[base + pick] = tag[31:0];
      way_valid[base + pick] = 1;
      way_stamp[base + pick] = lru_clock;
      if (n_miss != '1) n_miss++;
    end
    r.hit = hit;
    r.way_used = pick[3:0];
    r.access_count = n_access;
    r.miss_count = n_miss;
    return r;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx[1:0], 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_EPL: c_epl = val[6:0];
      REG_YLC: c_ylc = val[30:0];
      REG_SETS: c_sets = val[10:0];
      REG_WAYS: c_ways = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_request(bit vs, bit [30:0] idx, bit typed, out_res_t typed_res);
    out_res_t r;
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.vector_select = vs;
    in_data.element_index = idx;
    do @(posedge clk); while (!in_ready);
    r = cache_lookup(vs, idx);
    pending_q.push_back(typed ? typed_res : r);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = pending_q.pop_front();
        if (out_data.hit !== e.hit || out_data.way_used !== e.way_used ||
            out_data.access_count !== e.access_count ||
            out_data.miss_count !== e.miss_count) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     e.hit, e.way_used, e.access_count, e.miss_count,
                     out_data.hit, out_data.way_used, out_data.access_count,
                     out_data.miss_count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  vector_row_t rows[$];

  task automatic add_row(bit vs, bit [30:0] idx);
    vector_row_t v;
    v.vs = vs;
    v.idx = idx;
    v.typed = 0;
    rows.push_back(v);
  endtask

  task automatic add_typed(bit vs, bit [30:0] idx, bit h, bit [3:0] w, int a, int m);
    vector_row_t v;
    v.vs = vs;
    v.idx = idx;
    v.typed = 1;
    v.hit = h;
    v.way = w;
    v.acc = 48'(a);
    v.mis = 48'(m);
    rows.push_back(v);
  endtask

  task automatic run_phase(logic [6:0] epl, logic [30:0] ylc, logic [10:0] sets,
                           logic [4:0] ways, int count, bit pause_once);
    longint unsigned span;
    bit vs;
    bit [30:0] idx;
    reg_write(REG_EPL, {25'd0, epl});
    reg_write(REG_YLC, {1'b0, ylc});
    reg_write(REG_SETS, {21'd0, sets});
    reg_write(REG_WAYS, {27'd0, ways});
    span = ((epl == 0) ? 1 : epl) * ((sets == 0) ? 1 : sets) * 24;
    for (int n = 0; n < count; n++) begin
      if (pause_once && n == count / 2) begin
        while (pending_q.size() != 0) @(negedge clk);
      end
      vs = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 7) begin
        idx = 31'($urandom_range(0, int'(span > 32'h7fffffff ? 32'h7fffffff : span)));
      end else begin
        idx = 31'($urandom());
      end
      send_request(vs, idx, 1'b0, '0);
    end
    wait_drained();
  endtask

  initial begin
    out_res_t t;
    for (int i = 0; i < ENTRIES; i++) way_valid[i] = 0;
    lru_clock = '0;
    n_access = '0;
    n_miss = '0;
    c_epl = 7'd8;
    c_ylc = '0;
    c_sets = 11'd64;
    c_ways = 5'd8;

    add_typed(0, 31'd0, 0, 4'd0, 1, 1);
    add_typed(0, 31'd0, 1, 4'd0, 2, 1);
    add_typed(0, 31'd7, 1, 4'd0, 3, 1);
    add_typed(0, 31'd8, 0, 4'd0, 4, 2);
    add_typed(1, 31'd0, 1, 4'd0, 5, 2);
    add_row(0, 31'h7fffffff);
    add_row(1, 31'h7fffffff);
    for (int k = 1; k <= 8; k++) add_row(0, 31'(512 * k));
    add_row(0, 31'd0);
    add_row(0, 31'd512);
    add_row(1, 31'd4096);
    add_row(0, 31'h55555555);
    add_row(1, 31'h2aaaaaaa);
    add_row(0, 31'd1024);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      t.hit = rows[i].hit;
      t.way_used = rows[i].way;
      t.access_count = rows[i].acc;
      t.miss_count = rows[i].mis;
      send_request(rows[i].vs, rows[i].idx, rows[i].typed, t);
    end
    wait_drained();

    run_phase(7'd1, 31'd0, 11'd1, 5'd1, 70, 0);
    run_phase(7'd0, 31'd5, 11'd0, 5'd0, 70, 1);
    run_phase(7'd64, 31'd100, 11'd1024, 5'd16, 70, 0);
    run_phase(7'd127, 31'h7fffffff, 11'd2047, 5'd31, 70, 0);
    run_phase(7'd3, 31'd17, 11'd7, 5'd4, 70, 0);
    sender_idle_on = 0;
    receiver_idle_on = 0;
    run_phase(7'd8, 31'd0, 11'd64, 5'd8, 70, 0);

    if (errors == 0 && pending_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
